// ----- rtl/dpd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpd_pkg: shared types and constants for the DTMF packet deframer
// Request and result structs, result codes, tone characters and the
// tone-to-nibble mapping.
// ----------------------------------------------------------------------------
package dpd_pkg;

    // Packet framing
    localparam int MAX_TONES_DEF = 80;
    localparam int HDR_TONES     = 10;
    localparam int HDR_IDX_W     = $clog2(HDR_TONES);
    localparam int FIFO_DEPTH    = 2;

    // Tone characters
    localparam logic [7:0] CHAR_STAR = 8'h2A;
    localparam logic [7:0] CHAR_HASH = 8'h23;

    // Checksum seed nibbles and type limit
    localparam logic [7:0] SUM_SEED_STAR = 8'h0E;
    localparam logic [7:0] SUM_SEED_HASH = 8'h0F;
    localparam logic [7:0] TYPE_MAX      = 8'd6;
    localparam logic [7:0] NIBBLE_BAD    = 8'hFF;

    // Header tone positions
    localparam int POS_TYPE  = 2;
    localparam int POS_ID    = 3;
    localparam int POS_SUM_H = 8;
    localparam int POS_SUM_L = 9;

    // Result kind codes
    localparam logic [1:0] KIND_TAKEN   = 2'd0;
    localparam logic [1:0] KIND_FWD     = 2'd1;
    localparam logic [1:0] KIND_PACKET  = 2'd2;
    localparam logic [1:0] KIND_NOTHING = 2'd3;

    // Error codes
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_LENGTH = 2'd1;
    localparam logic [1:0] ERR_TYPE   = 2'd2;
    localparam logic [1:0] ERR_CSUM   = 2'd3;

    // Input request
    typedef struct packed {
        logic       command;
        logic [7:0] tone_char;
    } dpd_in_t;

    // Result
    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] error;
        logic [7:0] packet_type;
        logic [9:0] sender_id;
        logic [9:0] receiver_id;
        logic [7:0] received_checksum;
        logic [7:0] computed_checksum;
    } dpd_out_t;

    // Classified request from front to back
    typedef struct packed {
        logic [1:0]                     kind;
        logic                           len_err;
        logic [HDR_TONES-1:0][7:0]      tones;
    } dpd_mid_t;

    // Tone character to nibble, invalid characters give 0xFF
    function automatic logic [7:0] tone_nibble(input logic [7:0] c);
        logic [7:0] n;
        case (c) inside
            [8'h30:8'h39]: n = c - 8'h30;
            8'h41:         n = 8'h0A;
            8'h42:         n = 8'h0B;
            8'h43:         n = 8'h0C;
            8'h44:         n = 8'h0D;
            CHAR_STAR:     n = 8'h0E;
            CHAR_HASH:     n = 8'h0F;
            default:       n = NIBBLE_BAD;
        endcase
        return n;
    endfunction

endpackage

// ----- rtl/dpd_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpd_fifo: small register queue
// Push/full and pop/empty request queue; head shown while not empty.
// ----------------------------------------------------------------------------
module dpd_fifo
    import dpd_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = FIFO_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    // Fill count stays in range
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("fifo count beyond depth");

    // Pointers agree with the fill count when empty or full
    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (empty || full) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("fifo pointers disagree with count");

    // A push into a non-full queue without pop grows the count
    a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("fifo count did not grow on push");

endmodule

// ----- rtl/dpd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpd_front: preamble hunt and tone collection
// Tracks the star/hash preamble, forwarding mode and tone count, stores the
// header tones and emits one classified request per accepted input.
// ----------------------------------------------------------------------------
module dpd_front
    import dpd_pkg::*;
#(
    parameter int MAX_TONES = MAX_TONES_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  dpd_in_t  item,
    output dpd_mid_t req
);

    localparam int COUNT_W = $clog2(MAX_TONES + 2);

    typedef enum logic [2:0] {
        ST_STAR    = 3'b001,
        ST_HASH    = 3'b010,
        ST_COLLECT = 3'b100
    } hunt_t;

    hunt_t              stage_reg, stage_next;
    logic               fwd_reg, fwd_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [7:0]         tones_reg [HDR_TONES];
    logic               wr_en;
    logic [HDR_IDX_W-1:0] wr_idx;
    logic [1:0]         kind;
    logic               len_err;
    logic               store;

    // Classification and next state
    always_comb
    begin
        stage_next = stage_reg;
        fwd_next   = fwd_reg;
        count_next = count_reg;
        kind       = KIND_NOTHING;
        len_err    = 1'b0;
        store      = 1'b0;
        wr_en      = 1'b0;
        wr_idx     = count_reg[HDR_IDX_W-1:0];

        if (!item.command)
        begin
            if (fwd_reg)
            begin
                kind = KIND_FWD;
            end
            else
            begin
                case (stage_reg)
                    ST_HASH:
                    begin
                        if (item.tone_char == CHAR_HASH)
                        begin
                            stage_next = ST_COLLECT;
                            store      = 1'b1;
                            kind       = KIND_TAKEN;
                        end
                        else
                        begin
                            fwd_next   = 1'b1;
                            stage_next = ST_STAR;
                            count_next = '0;
                            kind       = KIND_FWD;
                        end
                    end
                    ST_COLLECT:
                    begin
                        store = 1'b1;
                        kind  = KIND_TAKEN;
                    end
                    default:
                    begin
                        count_next = '0;
                        if (item.tone_char == CHAR_STAR)
                        begin
                            stage_next = ST_HASH;
                            wr_en      = 1'b1;
                            wr_idx     = '0;
                            count_next = COUNT_W'(1);
                            kind       = KIND_TAKEN;
                        end
                        else
                        begin
                            fwd_next = 1'b1;
                            kind     = KIND_FWD;
                        end
                    end
                endcase
            end
        end
        else
        begin
            // End of reception
            if (fwd_reg)
            begin
                fwd_next = 1'b0;
                kind     = KIND_NOTHING;
            end
            else if (stage_reg == ST_COLLECT)
            begin
                stage_next = ST_STAR;
                count_next = '0;
                kind       = KIND_PACKET;
                len_err    = (count_reg > COUNT_W'(MAX_TONES)) ||
                             (count_reg < COUNT_W'(HDR_TONES));
            end
            else
            begin
                kind = KIND_NOTHING;
            end
        end

        // Store into the header and saturate the count
        if (store)
        begin
            wr_en = (count_reg < COUNT_W'(HDR_TONES));
            if (count_reg < COUNT_W'(MAX_TONES + 1))
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= ST_STAR;
            fwd_reg   <= 1'b0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            stage_reg <= stage_next;
            fwd_reg   <= fwd_next;
            count_reg <= count_next;
        end
    end

    // Header tone store
    always_ff @(posedge clk)
    begin
        if (accept && wr_en)
        begin
            tones_reg[wr_idx] <= item.tone_char;
        end
    end

    // Request towards the back end
    always_comb
    begin
        req.kind    = kind;
        req.len_err = len_err;
        for (int i = 0; i < HDR_TONES; i++)
        begin
            req.tones[i] = tones_reg[i];
        end
    end

    // Forwarding only happens with the hunt reset
    a_fwd_stage: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg |-> (stage_reg == ST_STAR))
        else $error("forwarding with preamble in progress");

    // Count saturates one above the maximum
    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(MAX_TONES + 1))
        else $error("tone count overran");

    // Waiting for hash means exactly the star was stored
    a_hash_count: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_reg == ST_HASH) |-> (count_reg == COUNT_W'(1)))
        else $error("tone count wrong while waiting for hash");

    // A decode request always leaves the hunt at the start
    a_decode_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && kind == KIND_PACKET) |=> (stage_reg == ST_STAR && count_reg == '0))
        else $error("hunt not reset after decode");

endmodule

// ----- rtl/dpd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpd_back: packet decode
// Maps header tones to nibbles, extracts type, IDs and checksum, checks the
// packet and pushes one result per request into the result queue.
// ----------------------------------------------------------------------------
module dpd_back
    import dpd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  dpd_mid_t req,
    input  logic     req_empty,
    output logic     req_pop,
    output dpd_out_t res,
    output logic     res_push,
    input  logic     res_full
);

    logic [7:0]  nib [HDR_TONES];
    logic [7:0]  ptype;
    logic [7:0]  sum;
    logic [7:0]  rx_sum;
    logic [23:0] idw;
    logic [1:0]  err;

    // Move a request whenever the result queue has room
    assign req_pop  = !req_empty && !res_full;
    assign res_push = req_pop;

    // Nibble mapping per header tone
    always_comb
    begin
        for (int i = 0; i < HDR_TONES; i++)
        begin
            nib[i] = tone_nibble(req.tones[i]);
        end
    end

    // Field extraction and checksum
    always_comb
    begin
        ptype  = nib[POS_TYPE];
        sum    = SUM_SEED_STAR + SUM_SEED_HASH + ptype + nib[POS_ID] + nib[POS_ID+1] +
                 nib[POS_ID+2] + nib[POS_ID+3] + nib[POS_ID+4];
        // invalid nibbles spill their high bits into the preceding, more significant ID digit
        idw    = {nib[POS_ID],   16'h0000} | {4'h0, nib[POS_ID+1], 12'h000} |
                 {8'h00, nib[POS_ID+2], 8'h00} | {12'h000, nib[POS_ID+3], 4'h0} |
                 {16'h0000, nib[POS_ID+4]};
        rx_sum = {nib[POS_SUM_H][3:0], 4'h0} | nib[POS_SUM_L];
        if (ptype > TYPE_MAX)
        begin
            err = ERR_TYPE;
        end
        else if (rx_sum != sum)
        begin
            err = ERR_CSUM;
        end
        else
        begin
            err = ERR_NONE;
        end
    end

    // Result assembly
    always_comb
    begin
        res      = '0;
        res.kind = req.kind;
        if (req.kind == KIND_PACKET)
        begin
            if (req.len_err)
            begin
                res.error = ERR_LENGTH;
            end
            else
            begin
                res.error             = err;
                res.packet_type       = ptype;
                res.sender_id         = idw[19:10];
                res.receiver_id       = idw[9:0];
                res.received_checksum = rx_sum;
                res.computed_checksum = sum;
            end
        end
    end

    // Only decoded packets carry an error or payload
    a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res.kind != KIND_PACKET) |->
            (res.error == ERR_NONE && res.computed_checksum == 8'h00))
        else $error("payload on a non-packet result");

    // A length error clears every other field
    a_len_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res.error == ERR_LENGTH) |->
            (res.packet_type == 8'h00 && res.sender_id == 10'h000 &&
             res.received_checksum == 8'h00))
        else $error("fields set on a length error");

    // Pop and push move together
    a_pop_push: assert property (@(posedge clk) disable iff (!rst_n)
        req_pop |-> (!res_full && !req_empty))
        else $error("request moved without room");

endmodule

// ----- rtl/dtmf_packet_deframer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtmf_packet_deframer_core: DTMF packet deframer top level
// Path: the combinational front classifies each accepted request into the
// request queue; the combinational back decodes it into the result queue,
// one result per request, and waits while the result queue is full.
// Throughput: one request per cycle while not full; two-entry queues.
// Reset: asynchronous, active low; hunt, forwarding, count and queues clear.
// Header tone storage is not reset; decode reads only tones of that packet.
// ----------------------------------------------------------------------------
module dtmf_packet_deframer_core
    import dpd_pkg::*;
#(
    parameter int MAX_TONES = MAX_TONES_DEF,
    parameter int Q_DEPTH   = FIFO_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  dpd_in_t  item,
    output logic     full,
    input  logic     pop,
    output dpd_out_t result,
    output logic     empty
);

    localparam int MID_W = $bits(dpd_mid_t);
    localparam int OUT_W = $bits(dpd_out_t);

    logic             accept;
    dpd_mid_t         front_req;
    dpd_mid_t         mid_head;
    logic [MID_W-1:0] mid_rdata;
    logic             mid_empty;
    logic             mid_pop;
    dpd_out_t         back_res;
    logic             res_push;
    logic             res_full;
    logic [OUT_W-1:0] res_rdata;

    assign accept   = push && !full;
    assign mid_head = dpd_mid_t'(mid_rdata);
    assign result   = dpd_out_t'(res_rdata);

    // Front: preamble hunt and classification
    dpd_front #(
        .MAX_TONES (MAX_TONES)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .req    (front_req)
    );

    // Queue between front and back
    dpd_fifo #(
        .WIDTH (MID_W),
        .DEPTH (Q_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_req),
        .full  (full),
        .pop   (mid_pop),
        .rdata (mid_rdata),
        .empty (mid_empty)
    );

    // Back: packet decode
    dpd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (mid_head),
        .req_empty (mid_empty),
        .req_pop   (mid_pop),
        .res       (back_res),
        .res_push  (res_push),
        .res_full  (res_full)
    );

    // Result queue
    dpd_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (Q_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (back_res),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

endmodule
